// ===== hdl/credit_based_tx_rate_stepper_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the credit based transmit rate stepper
// Shared property wrappers; all sample on clk and are held off during reset.
// ----------------------------------------------------------------------------
`ifndef CREDIT_BASED_TX_RATE_STEPPER_CORE_DEFINES_SVH
`define CREDIT_BASED_TX_RATE_STEPPER_CORE_DEFINES_SVH

// Same-cycle implication.
`define CBTRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CBTRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cbtrs_pkg.sv =====
// ----------------------------------------------------------------------------
// cbtrs_pkg
// Types and constants shared by the rate stepper interfaces and core.
// ----------------------------------------------------------------------------
package cbtrs_pkg;

    typedef enum logic
    {
        CMD_REPORT = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_t;

    typedef enum logic
    {
        REG_RAISE_THRESHOLD = 1'b0,
        REG_RATE_COUNT      = 1'b1
    } reg_idx_t;

    localparam int RATE_W   = 4;
    localparam int TRIES_W  = 4;
    localparam int THR_W    = 8;
    localparam int RCNT_W   = 5;
    localparam int CNT_W    = 16;
    localparam int CREDIT_W = 8;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [THR_W-1:0]  RAISE_THRESHOLD_RST = 8'd10;
    localparam logic [RCNT_W-1:0] RATE_COUNT_RST      = 5'd16;
    localparam int                RATE_CAP            = 16;

endpackage

// ===== hdl/cbtrs_item_if.sv =====
// ----------------------------------------------------------------------------
// cbtrs_item_if
// Input channel: status report or update tick, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbtrs_item_if;

    logic                               valid;
    logic                               ready;
    logic                               command;
    logic                               acked;
    logic [cbtrs_pkg::RATE_W-1:0]       first_rate;
    logic [cbtrs_pkg::TRIES_W-1:0]      first_tries;

    modport source
    (
        output valid,
        input  ready,
        output command,
        output acked,
        output first_rate,
        output first_tries
    );

    modport sink
    (
        input  valid,
        output ready,
        input  command,
        input  acked,
        input  first_rate,
        input  first_tries
    );

endinterface

// ===== hdl/cbtrs_result_if.sv =====
// ----------------------------------------------------------------------------
// cbtrs_result_if
// Result channel: current rate and retry fallbacks, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbtrs_result_if;

    logic                               valid;
    logic                               ready;
    logic [cbtrs_pkg::RATE_W-1:0]       current_rate;
    logic [cbtrs_pkg::RATE_W-1:0]       fallback_one;
    logic [cbtrs_pkg::RATE_W-1:0]       fallback_two;
    logic                               rate_changed;

    modport source
    (
        output valid,
        input  ready,
        output current_rate,
        output fallback_one,
        output fallback_two,
        output rate_changed
    );

    modport sink
    (
        input  valid,
        output ready,
        input  current_rate,
        input  fallback_one,
        input  fallback_two,
        input  rate_changed
    );

endinterface

// ===== hdl/credit_based_tx_rate_stepper_core.sv =====
// ----------------------------------------------------------------------------
// credit_based_tx_rate_stepper_core
// Per-station transmit rate controller with credit based rate raising.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while the result register is not stalled. A beat
// lands in an input register, is processed by the update logic against the
// rate/counter state, and the result is held in an output register. The state
// update (counters, credit and rate rule) sets the throughput of one beat per
// clock; a stalled result register holds one beat in the input register before
// the input side backs up.
// Reports count only when their first-attempt rate matches the current rate.
// A tick runs the decrease/credit/raise rule once. The APB port holds
// raise_threshold at 0x0 and rate_count at 0x4; write them only while idle.
// ----------------------------------------------------------------------------
`include "credit_based_tx_rate_stepper_core_defines.svh"

module credit_based_tx_rate_stepper_core
#(
    parameter int RATE_SLOTS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cbtrs_pkg::ADDR_W-1:0]        paddr,
    input  logic [cbtrs_pkg::DATA_W-1:0]        pwdata,
    output logic [cbtrs_pkg::DATA_W-1:0]        prdata,
    output logic                                pready,

    cbtrs_item_if.sink                          item,
    cbtrs_result_if.source                      result
);

    localparam int SLOT_CAP = (RATE_SLOTS > cbtrs_pkg::RATE_CAP) ?
                              cbtrs_pkg::RATE_CAP : RATE_SLOTS;
    localparam logic [cbtrs_pkg::RCNT_W-1:0] SLOT_CAP_W = cbtrs_pkg::RCNT_W'(SLOT_CAP);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [cbtrs_pkg::THR_W-1:0]    thr_reg;
    logic [cbtrs_pkg::RCNT_W-1:0]   rcnt_reg;
    logic                           cfg_wr;
    cbtrs_pkg::reg_idx_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = cbtrs_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= cbtrs_pkg::RAISE_THRESHOLD_RST;
            rcnt_reg <= cbtrs_pkg::RATE_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                cbtrs_pkg::REG_RAISE_THRESHOLD: thr_reg  <= pwdata[cbtrs_pkg::THR_W-1:0];
                cbtrs_pkg::REG_RATE_COUNT:      rcnt_reg <= pwdata[cbtrs_pkg::RCNT_W-1:0];
                default:                        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            cbtrs_pkg::REG_RAISE_THRESHOLD:
                prdata = {{(cbtrs_pkg::DATA_W-cbtrs_pkg::THR_W){1'b0}}, thr_reg};
            cbtrs_pkg::REG_RATE_COUNT:
                prdata = {{(cbtrs_pkg::DATA_W-cbtrs_pkg::RCNT_W){1'b0}}, rcnt_reg};
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register and handshake
    // ------------------------------------------------------------------
    logic                               in_valid_reg;
    logic                               in_cmd_reg;
    logic                               in_acked_reg;
    logic [cbtrs_pkg::RATE_W-1:0]       in_frate_reg;
    logic [cbtrs_pkg::TRIES_W-1:0]      in_tries_reg;
    logic                               out_valid_reg;
    logic                               in_fire;
    logic                               proc_fire;

    assign proc_fire  = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || proc_fire;
    assign in_fire    = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_cmd_reg   <= item.command;
            in_acked_reg <= item.acked;
            in_frate_reg <= item.first_rate;
            in_tries_reg <= item.first_tries;
        end
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [cbtrs_pkg::RATE_W-1:0]       rate_reg,   rate_next;
    logic [cbtrs_pkg::CNT_W-1:0]        ok_reg,     ok_next;
    logic [cbtrs_pkg::CNT_W-1:0]        err_reg,    err_next;
    logic [cbtrs_pkg::CNT_W-1:0]        retry_reg,  retry_next;
    logic [cbtrs_pkg::CREDIT_W-1:0]     credit_reg, credit_next;

    // report path: 17-bit sums saturate at the 16-bit maximum
    logic [cbtrs_pkg::CNT_W:0]          ok_sum, err_sum, retry_sum;
    logic [cbtrs_pkg::CNT_W-1:0]        ok_rep, err_rep, retry_rep;
    logic [1:0]                         err_inc;
    logic                               rep_hit;

    // tick path
    logic                               is_tick;
    logic                               enough;
    logic [cbtrs_pkg::CNT_W:0]          frames;
    logic [19:0]                        ok_x3, err_x10, err_x10p;
    logic                               err_ge_thres, err_le_thres;
    logic                               c1, c2, c3, c4;
    logic [cbtrs_pkg::RATE_W-1:0]       r1, r2, r3a, r3;
    logic [5:0]                         r3x3;
    logic [cbtrs_pkg::CREDIT_W-1:0]     cr_a, cr_b;
    logic                               raise;
    logic [cbtrs_pkg::RCNT_W-1:0]       limit, r3_inc;
    logic [cbtrs_pkg::RATE_W-1:0]       r4;
    logic                               changed;

    assign is_tick = (in_cmd_reg == cbtrs_pkg::CMD_TICK);
    assign rep_hit = (in_frate_reg == rate_reg);

    always_comb
    begin
        if (!in_acked_reg)
            err_inc = 2'd2;
        else if (in_tries_reg > 4'd1)
            err_inc = 2'd1;
        else
            err_inc = 2'd0;
    end

    assign ok_sum    = {1'b0, ok_reg} + {{cbtrs_pkg::CNT_W{1'b0}}, in_acked_reg};
    assign err_sum   = {1'b0, err_reg} + {{(cbtrs_pkg::CNT_W-1){1'b0}}, err_inc};
    assign retry_sum = {1'b0, retry_reg} +
                       {{(cbtrs_pkg::CNT_W+1-cbtrs_pkg::TRIES_W){1'b0}}, in_tries_reg};
    assign ok_rep    = ok_sum[cbtrs_pkg::CNT_W]    ? '1 : ok_sum[cbtrs_pkg::CNT_W-1:0];
    assign err_rep   = err_sum[cbtrs_pkg::CNT_W]   ? '1 : err_sum[cbtrs_pkg::CNT_W-1:0];
    assign retry_rep = retry_sum[cbtrs_pkg::CNT_W] ? '1 : retry_sum[cbtrs_pkg::CNT_W-1:0];

    // thres = ok*3/10 without a divider:
    //   err >= thres  <=>  10*(err+1) > 3*ok
    //   err <= thres  <=>  10*err    <= 3*ok
    assign frames       = {1'b0, ok_reg} + {1'b0, err_reg};
    assign enough       = frames >= {{(cbtrs_pkg::CNT_W+1-cbtrs_pkg::THR_W){1'b0}}, thr_reg};
    assign ok_x3        = {3'b0, ok_reg, 1'b0} + {4'b0, ok_reg};
    assign err_x10      = {1'b0, err_reg, 3'b0} + {3'b0, err_reg, 1'b0};
    assign err_x10p     = err_x10 + 20'd10;
    assign err_ge_thres = err_x10p > ok_x3;
    assign err_le_thres = err_x10 <= ok_x3;

    assign c1 = enough && (err_reg != '0) && (ok_reg == '0);
    assign c2 = enough && (ok_reg < retry_reg);
    assign c3 = enough && err_ge_thres;

    assign r1   = (c1 && rate_reg != '0) ? rate_reg - 4'd1 : rate_reg;
    assign r2   = (c2 && r1 != '0) ? r1 - 4'd1 : r1;
    assign r3a  = (r2 != '0) ? r2 - 4'd1 : r2;
    assign r3x3 = {2'b0, r3a} + {1'b0, r3a, 1'b0};
    always_comb
    begin
        if (!c3)
            r3 = r2;
        else if (err_reg > ok_reg && r3a >= 4'd4)
            r3 = r3x3[5:2];
        else
            r3 = r3a;
    end

    // credit cleared by any decrease, then a good period may add one
    assign cr_a  = (c1 || c2 || c3) ? '0 : credit_reg;
    assign c4    = enough && err_le_thres && (cr_a != '1);
    assign cr_b  = c4 ? cr_a + 8'd1 : cr_a;
    assign raise = cr_b >= thr_reg;

    assign limit  = (rcnt_reg > SLOT_CAP_W) ? SLOT_CAP_W : rcnt_reg;
    assign r3_inc = {1'b0, r3} + 5'd1;
    assign r4     = (raise && r3_inc < limit) ? r3_inc[cbtrs_pkg::RATE_W-1:0] : r3;

    assign changed = is_tick && (r4 != rate_reg);

    always_comb
    begin
        rate_next   = rate_reg;
        ok_next     = ok_reg;
        err_next    = err_reg;
        retry_next  = retry_reg;
        credit_next = credit_reg;
        if (!is_tick)
        begin
            if (rep_hit)
            begin
                ok_next    = ok_rep;
                err_next   = err_rep;
                retry_next = retry_rep;
            end
        end
        else if (changed)
        begin
            rate_next   = r4;
            ok_next     = '0;
            err_next    = '0;
            retry_next  = '0;
            credit_next = '0;
        end
        else
        begin
            credit_next = raise ? '0 : cr_b;
            if (enough)
            begin
                ok_next    = '0;
                err_next   = '0;
                retry_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= '0;
            ok_reg     <= '0;
            err_reg    <= '0;
            retry_reg  <= '0;
            credit_reg <= '0;
        end
        else if (proc_fire)
        begin
            rate_reg   <= rate_next;
            ok_reg     <= ok_next;
            err_reg    <= err_next;
            retry_reg  <= retry_next;
            credit_reg <= credit_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [cbtrs_pkg::RATE_W-1:0]   res_rate_reg;
    logic [cbtrs_pkg::RATE_W-1:0]   res_fb1_reg;
    logic [cbtrs_pkg::RATE_W-1:0]   res_fb2_reg;
    logic                           res_chg_reg;
    logic [cbtrs_pkg::RATE_W-1:0]   fb1, fb2, fb_dec;

    assign fb_dec = rate_next - 4'd1;
    assign fb1    = (rate_next != '0) ? fb_dec : '0;
    always_comb
    begin
        if (rate_next >= 4'd4)
            fb2 = fb_dec >> 1;
        else if (rate_next >= 4'd2)
            fb2 = rate_next - 4'd2;
        else
            fb2 = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            res_rate_reg <= rate_next;
            res_fb1_reg  <= fb1;
            res_fb2_reg  <= fb2;
            res_chg_reg  <= changed;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.current_rate = res_rate_reg;
    assign result.fallback_one = res_fb1_reg;
    assign result.fallback_two = res_fb2_reg;
    assign result.rate_changed = res_chg_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CBTRS_ASSERT_NEXT(a_report_keeps_rate, proc_fire && !is_tick, $stable(rate_reg),
        "report beat moved the rate")
    `CBTRS_ASSERT_NEXT(a_change_clears, proc_fire && changed,
        ok_reg == '0 && err_reg == '0 && retry_reg == '0 && credit_reg == '0,
        "rate change left counters set")
    `CBTRS_ASSERT_NEXT(a_idle_holds_state, !proc_fire,
        $stable(rate_reg) && $stable(ok_reg) && $stable(err_reg) &&
        $stable(retry_reg) && $stable(credit_reg),
        "state moved without a beat")
    `CBTRS_ASSERT_NOW(a_stall_only_when_full, in_valid_reg && !proc_fire,
        out_valid_reg && !result.ready,
        "input beat stalled with room in the result register")

endmodule

// ===== test/tb_credit_based_tx_rate_stepper_core.sv =====
// ----------------------------------------------------------------------------
// tb_credit_based_tx_rate_stepper_core
// Self-checking bench for the credit based transmit rate stepper. Report and
// tick beats go in over the item channel while a local predictor of the
// counters, credit and rate rule computes each expected result. Results are
// compared field by field, in order. Both channels idle and stall in random
// bursts. APB writes are read back. The run ends with a stall-free pass of
// back-to-back beats.
// ----------------------------------------------------------------------------
module tb_credit_based_tx_rate_stepper_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RATE_SLOTS = 16;
    localparam int COUNT_MAX  = (1 << cbtrs_pkg::CNT_W) - 1;
    localparam int CREDIT_MAX = (1 << cbtrs_pkg::CREDIT_W) - 1;
    localparam int RATE_TOP   = (1 << cbtrs_pkg::RATE_W) - 1;

    typedef struct packed
    {
        cbtrs_pkg::cmd_t                    command;
        logic                               acked;
        logic [cbtrs_pkg::RATE_W-1:0]       first_rate;
        logic [cbtrs_pkg::TRIES_W-1:0]      first_tries;
    } tx_item_t;

    typedef struct packed
    {
        logic [cbtrs_pkg::RATE_W-1:0]       current_rate;
        logic [cbtrs_pkg::RATE_W-1:0]       fallback_one;
        logic [cbtrs_pkg::RATE_W-1:0]       fallback_two;
        logic                               rate_changed;
    } rate_result_t;

    typedef enum
    {
        MIX_CLEAN,
        MIX_LOSSY,
        MIX_RETRY,
        MIX_NOISE
    } traffic_mix_t;

    logic                               clk;
    logic                               rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [cbtrs_pkg::ADDR_W-1:0]       paddr;
    logic [cbtrs_pkg::DATA_W-1:0]       pwdata;
    logic [cbtrs_pkg::DATA_W-1:0]       prdata;
    logic                               pready;

    cbtrs_item_if           item_ch();
    cbtrs_result_if         result_ch();

    // predictor state
    logic [cbtrs_pkg::RATE_W-1:0]       cur_rate   = '0;
    int unsigned                        ok_cnt     = 0;
    int unsigned                        err_cnt    = 0;
    int unsigned                        retry_cnt  = 0;
    int unsigned                        credit_cnt = 0;
    logic [cbtrs_pkg::THR_W-1:0]        thr_cfg    = cbtrs_pkg::RAISE_THRESHOLD_RST;
    logic [cbtrs_pkg::RCNT_W-1:0]       rc_cfg     = cbtrs_pkg::RATE_COUNT_RST;

    rate_result_t           expected_rates[$];
    rate_result_t           head_res;
    int unsigned            fail_count = 0;
    int unsigned            items_sent = 0;
    bit                     idle_on    = 1'b1;

    credit_based_tx_rate_stepper_core
    #(
        .RATE_SLOTS (RATE_SLOTS)
    )
    uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .item       (item_ch),
        .result     (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int unsigned sat_count(int unsigned a, int unsigned b);
        return (a + b > COUNT_MAX) ? COUNT_MAX : a + b;
    endfunction

    function automatic int unsigned lower_rate(int unsigned r);
        return (r > 0) ? r - 1 : 0;
    endfunction

    // Advance the predictor by one beat and return the result it should cause.
    function automatic rate_result_t apply_item(tx_item_t it);
        int unsigned    r;
        int unsigned    thres;
        int unsigned    lim;
        bit             enough;
        int             f;
        logic [cbtrs_pkg::RATE_W-1:0] prev;
        rate_result_t   res;

        prev = cur_rate;
        if (it.command == cbtrs_pkg::CMD_REPORT)
        begin
            if (it.first_rate == cur_rate)
            begin
                ok_cnt = sat_count(ok_cnt, it.acked);
                if (!it.acked)
                    err_cnt = sat_count(err_cnt, 2);
                else if (it.first_tries > 1)
                    err_cnt = sat_count(err_cnt, 1);
                retry_cnt = sat_count(retry_cnt, it.first_tries);
            end
        end
        else
        begin
            r      = cur_rate;
            thres  = ok_cnt * 3 / 10;
            enough = (ok_cnt + err_cnt) >= thr_cfg;
            lim    = rc_cfg;
            if (lim > RATE_SLOTS)
                lim = RATE_SLOTS;
            if (lim > cbtrs_pkg::RATE_CAP)
                lim = cbtrs_pkg::RATE_CAP;

            if (enough && err_cnt > 0 && ok_cnt == 0)
            begin
                r = lower_rate(r);
                credit_cnt = 0;
            end
            if (enough && ok_cnt < retry_cnt)
            begin
                r = lower_rate(r);
                credit_cnt = 0;
            end
            if (enough && err_cnt >= thres)
            begin
                r = lower_rate(r);
                if (err_cnt > ok_cnt && r >= 4)
                    r = r * 3 / 4;
                credit_cnt = 0;
            end
            if (enough && err_cnt <= thres && credit_cnt < CREDIT_MAX)
                credit_cnt++;

            if (credit_cnt >= thr_cfg)
            begin
                credit_cnt = 0;
                if (r + 1 < lim)
                    r++;
            end

            if (r != cur_rate)
            begin
                cur_rate   = cbtrs_pkg::RATE_W'(r);
                ok_cnt     = 0;
                err_cnt    = 0;
                retry_cnt  = 0;
                credit_cnt = 0;
            end
            else if (enough)
            begin
                ok_cnt    = 0;
                err_cnt   = 0;
                retry_cnt = 0;
            end
        end

        f = int'(cur_rate) - 1;
        res.fallback_one = (f >= 0) ? cbtrs_pkg::RATE_W'(f) : '0;
        if (f > 2)
            f = f / 2;
        else
            f = f - 1;
        res.fallback_two = (f >= 0) ? cbtrs_pkg::RATE_W'(f) : '0;
        res.current_rate = cur_rate;
        res.rate_changed = (cur_rate != prev);
        return res;
    endfunction

    task automatic check_field(string label, logic [cbtrs_pkg::DATA_W-1:0] want,
                               logic [cbtrs_pkg::DATA_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, label, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_rates.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result beat, expected none actual rate %0h",
                         $time, result_ch.current_rate);
            end
            else
            begin
                head_res = expected_rates.pop_front();
                check_field("current_rate", cbtrs_pkg::DATA_W'(head_res.current_rate),
                            cbtrs_pkg::DATA_W'(result_ch.current_rate));
                check_field("fallback_one", cbtrs_pkg::DATA_W'(head_res.fallback_one),
                            cbtrs_pkg::DATA_W'(result_ch.fallback_one));
                check_field("fallback_two", cbtrs_pkg::DATA_W'(head_res.fallback_two),
                            cbtrs_pkg::DATA_W'(result_ch.fallback_two));
                check_field("rate_changed", cbtrs_pkg::DATA_W'(head_res.rate_changed),
                            cbtrs_pkg::DATA_W'(result_ch.rate_changed));
            end
        end
    end

    // result side backpressure: random stall bursts, with quiet stretches
    initial
    begin : result_stall
        int unsigned n;

        result_ch.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 14);
                result_ch.ready = 1'b0;
                repeat (n) @(negedge clk);
                result_ch.ready = 1'b1;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end
        end
    end

    task automatic send_item(cbtrs_pkg::cmd_t cmd, logic ack,
                             logic [cbtrs_pkg::RATE_W-1:0] rate,
                             logic [cbtrs_pkg::TRIES_W-1:0] tries);
        tx_item_t       it;
        int unsigned    gap;

        it.command     = cmd;
        it.acked       = ack;
        it.first_rate  = rate;
        it.first_tries = tries;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            item_ch.valid       = 1'b0;
            item_ch.command     = 1'($urandom);
            item_ch.acked       = 1'($urandom);
            item_ch.first_rate  = cbtrs_pkg::RATE_W'($urandom);
            item_ch.first_tries = cbtrs_pkg::TRIES_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        item_ch.valid       = 1'b1;
        item_ch.command     = it.command;
        item_ch.acked       = it.acked;
        item_ch.first_rate  = it.first_rate;
        item_ch.first_tries = it.first_tries;
        do
            @(posedge clk);
        while (!item_ch.ready);
        expected_rates.push_back(apply_item(it));
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(cbtrs_pkg::CMD_TICK, 1'($urandom), cbtrs_pkg::RATE_W'($urandom),
                  cbtrs_pkg::TRIES_W'($urandom));
    endtask

    task automatic send_report(traffic_mix_t mix);
        cbtrs_pkg::cmd_t                    cmd;
        logic                               ack;
        logic [cbtrs_pkg::RATE_W-1:0]       rate;
        logic [cbtrs_pkg::TRIES_W-1:0]      tries;

        cmd  = cbtrs_pkg::CMD_REPORT;
        rate = ($urandom_range(0, 19) == 0) ? cbtrs_pkg::RATE_W'($urandom) : cur_rate;
        case (mix)
            MIX_CLEAN:
            begin
                ack   = ($urandom_range(0, 19) != 0);
                tries = cbtrs_pkg::TRIES_W'($urandom_range(0, 1));
            end
            MIX_LOSSY:
            begin
                ack   = ($urandom_range(0, 9) < 4);
                tries = cbtrs_pkg::TRIES_W'($urandom_range(1, 15));
            end
            MIX_RETRY:
            begin
                ack   = 1'b1;
                tries = cbtrs_pkg::TRIES_W'($urandom_range(2, 15));
            end
            default:
            begin
                rate  = cbtrs_pkg::RATE_W'($urandom);
                ack   = 1'($urandom);
                tries = cbtrs_pkg::TRIES_W'($urandom);
                if ($urandom_range(0, 7) == 0)
                    cmd = cbtrs_pkg::CMD_TICK;
            end
        endcase
        send_item(cmd, ack, rate, tries);
    endtask

    // a batch of reports closed by one evaluation tick
    task automatic run_period(traffic_mix_t mix, int unsigned len);
        for (int i = 0; i < len; i++)
            send_report(mix);
        send_tick();
    endtask

    function automatic traffic_mix_t pick_mix();
        int unsigned p;

        p = $urandom_range(0, 99);
        if (p < 45)
            return MIX_CLEAN;
        else if (p < 70)
            return MIX_LOSSY;
        else if (p < 85)
            return MIX_RETRY;
        return MIX_NOISE;
    endfunction

    task automatic drain_results();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (expected_rates.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // APB write followed by a readback of the same register
    task automatic reg_write(cbtrs_pkg::reg_idx_t idx, int unsigned value);
        logic [cbtrs_pkg::DATA_W-1:0] wdata;
        logic [cbtrs_pkg::DATA_W-1:0] want;

        drain_results();
        wdata = $urandom;
        if (idx == cbtrs_pkg::REG_RAISE_THRESHOLD)
        begin
            wdata[cbtrs_pkg::THR_W-1:0] = cbtrs_pkg::THR_W'(value);
            want = {{(cbtrs_pkg::DATA_W-cbtrs_pkg::THR_W){1'b0}},
                    wdata[cbtrs_pkg::THR_W-1:0]};
        end
        else
        begin
            wdata[cbtrs_pkg::RCNT_W-1:0] = cbtrs_pkg::RCNT_W'(value);
            want = {{(cbtrs_pkg::DATA_W-cbtrs_pkg::RCNT_W){1'b0}},
                    wdata[cbtrs_pkg::RCNT_W-1:0]};
        end

        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = cbtrs_pkg::ADDR_W'({idx, 2'b00});
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == cbtrs_pkg::REG_RAISE_THRESHOLD)
            thr_cfg = wdata[cbtrs_pkg::THR_W-1:0];
        else
            rc_cfg = wdata[cbtrs_pkg::RCNT_W-1:0];

        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("prdata", want, prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // reset values, report accounting corner cases, zero threshold, tiny limits
    task automatic test_directed();
        send_tick();
        send_item(cbtrs_pkg::CMD_REPORT, 1'b1, 4'd0, 4'd0);
        send_item(cbtrs_pkg::CMD_REPORT, 1'b1, 4'd0, 4'd15);
        send_item(cbtrs_pkg::CMD_REPORT, 1'b0, 4'd0, 4'd0);
        send_item(cbtrs_pkg::CMD_REPORT, 1'b0, 4'd15, 4'd15);
        send_item(cbtrs_pkg::CMD_REPORT, 1'b1, 4'd15, 4'd1);
        send_tick();
        repeat (5) send_item(cbtrs_pkg::CMD_REPORT, 1'b1, 4'd0, 4'd1);
        send_tick();

        reg_write(cbtrs_pkg::REG_RAISE_THRESHOLD, 0);
        send_tick();
        send_tick();
        reg_write(cbtrs_pkg::REG_RATE_COUNT, 1);
        send_tick();
        send_tick();
        reg_write(cbtrs_pkg::REG_RATE_COUNT, 0);
        send_tick();
        send_item(cbtrs_pkg::CMD_REPORT, 1'b0, cur_rate, 4'd15);
        send_tick();
    endtask

    // clean periods with a threshold of one should walk the rate to the top
    task automatic test_rate_climb();
        int unsigned guard;

        reg_write(cbtrs_pkg::REG_RAISE_THRESHOLD, 1);
        reg_write(cbtrs_pkg::REG_RATE_COUNT, 16);
        guard = 0;
        while (cur_rate < RATE_TOP && guard < 30)
        begin
            run_period(MIX_CLEAN, $urandom_range(3, 5));
            guard++;
        end
    endtask

    // limit dropped under the current rate: rate holds, then only falls
    task automatic test_rate_above_limit();
        reg_write(cbtrs_pkg::REG_RATE_COUNT, 3);
        run_period(MIX_CLEAN, 5);
        for (int i = 0; i < 6; i++)
            run_period(($urandom_range(0, 2) == 0) ? MIX_RETRY : MIX_LOSSY,
                       $urandom_range(3, 8));
        for (int i = 0; i < 3; i++)
            run_period(MIX_CLEAN, $urandom_range(4, 6));
    endtask

    task automatic random_phase(int unsigned thr, int unsigned rc, int unsigned budget);
        int unsigned stop_at;
        int unsigned len;

        reg_write(cbtrs_pkg::REG_RAISE_THRESHOLD, thr);
        reg_write(cbtrs_pkg::REG_RATE_COUNT, rc);
        stop_at = items_sent + budget;
        // a large threshold needs one long lossy batch to reach an evaluation
        if (thr > 40)
            run_period(MIX_LOSSY, thr / 2 + $urandom_range(5, 10));
        while (items_sent < stop_at)
        begin
            if (thr > 40)
                len = $urandom_range(0, 10);
            else
                len = $urandom_range(thr / 2, thr + 4);
            run_period(pick_mix(), len);
        end
    endtask

    task automatic test_random_phases();
        random_phase(0, 31, 20);
        random_phase(255, 16, 135);
        random_phase(1, 0, 12);
        random_phase(2, 1, 12);
        for (int i = 0; i < 2; i++)
            random_phase($urandom_range(2, 20), $urandom_range(2, 16), 20);
    endtask

    // stall-free tail: back-to-back reports and ticks with no idling
    task automatic test_stall_free_tail();
        idle_on = 1'b0;
        reg_write(cbtrs_pkg::REG_RAISE_THRESHOLD, 10);
        reg_write(cbtrs_pkg::REG_RATE_COUNT, 16);
        repeat (12)
            send_item(cbtrs_pkg::CMD_REPORT, 1'b1, cur_rate, 4'd15);
        send_item(cbtrs_pkg::CMD_REPORT, 1'b0, cur_rate, 4'd15);
        send_tick();
        for (int i = 0; i < 2; i++)
            run_period(pick_mix(), $urandom_range(8, 14));
    endtask

    task automatic finish_run();
        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        item_ch.valid       = 1'b0;
        item_ch.command     = cbtrs_pkg::CMD_REPORT;
        item_ch.acked       = 1'b0;
        item_ch.first_rate  = '0;
        item_ch.first_tries = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_rate_climb();
        test_rate_above_limit();
        test_random_phases();
        test_stall_free_tail();
        finish_run();
    end

endmodule
